/* design/bstk_pkg.sv */
// Shared constants, codes and control structures of the bounded stack.
package bstk_pkg;

    // Stack depth and derived widths.
    localparam int DEPTH   = 16;
    localparam int AW      = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int CMP_W   = (OCC_W > POS_W) ? OCC_W : POS_W;

    // Operation codes carried by an input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_UPDATE  = 3'd3,
        OP_DISPLAY = 3'd4
    } t_op;

    // Status codes carried by a result transaction.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    // Source of the result word.
    typedef enum logic [1:0] {
        DSEL_ZERO  = 2'd0,
        DSEL_VALUE = 2'd1,
        DSEL_MEM   = 2'd2
    } t_dsel;

    // Write address source: next free slot or the requested position.
    typedef enum logic {
        WSEL_TOP = 1'b0,
        WSEL_POS = 1'b1
    } t_wsel;

    // Read address source: top entry or the entry below the display cursor.
    typedef enum logic {
        RSEL_TOP  = 1'b0,
        RSEL_NEXT = 1'b1
    } t_rsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    mem_wr;
        t_wsel   wr_sel;
        logic    occ_inc;
        logic    occ_dec;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    cur_load;
        logic    cur_dec;
        logic    out_en;
        t_status out_status;
        t_dsel   out_dsel;
        logic    out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_ok;
        logic cur_zero;
    } t_dp_stat;

endpackage

/* design/bstk_ctrl.sv */
// Controller state machine of the bounded stack.
module bstk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [bstk_pkg::OP_W-1:0] i_op,
    input  bstk_pkg::t_dp_stat  i_stat,
    output bstk_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_DISP   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    bstk_pkg::t_op   r_op;

    // State and operation registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op <= bstk_pkg::t_op'(i_op);
        end
    end

    assign busy = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (r_op)
                    bstk_pkg::OP_PUSH: begin
                        o_cmd.out_en   = 1'b1;
                        o_cmd.out_last = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.out_status = bstk_pkg::ST_OVERFLOW;
                        end else begin
                            o_cmd.mem_wr   = 1'b1;
                            o_cmd.wr_sel   = bstk_pkg::WSEL_TOP;
                            o_cmd.occ_inc  = 1'b1;
                            o_cmd.out_dsel = bstk_pkg::DSEL_VALUE;
                        end
                    end
                    bstk_pkg::OP_POP, bstk_pkg::OP_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.out_en     = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = bstk_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = bstk_pkg::RSEL_TOP;
                            o_cmd.occ_dec = (r_op == bstk_pkg::OP_POP);
                            n_state       = S_RDWAIT;
                        end
                    end
                    bstk_pkg::OP_UPDATE: begin
                        o_cmd.out_en   = 1'b1;
                        o_cmd.out_last = 1'b1;
                        if (i_stat.empty) begin
                            o_cmd.out_status = bstk_pkg::ST_EMPTY;
                        end else if (!i_stat.pos_ok) begin
                            o_cmd.out_status = bstk_pkg::ST_BAD_POS;
                        end else begin
                            o_cmd.mem_wr = 1'b1;
                            o_cmd.wr_sel = bstk_pkg::WSEL_POS;
                        end
                    end
                    bstk_pkg::OP_DISPLAY: begin
                        if (i_stat.empty) begin
                            o_cmd.out_en     = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = bstk_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.rd_sel   = bstk_pkg::RSEL_TOP;
                            o_cmd.cur_load = 1'b1;
                            n_state        = S_DISP;
                        end
                    end
                    default: begin
                        // Unused codes produce no result.
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDWAIT: begin
                o_cmd.out_en   = 1'b1;
                o_cmd.out_last = 1'b1;
                o_cmd.out_dsel = bstk_pkg::DSEL_MEM;
                n_state        = S_IDLE;
            end
            S_DISP: begin
                // Emit the word read last cycle and fetch the one below it.
                o_cmd.out_en   = 1'b1;
                o_cmd.out_dsel = bstk_pkg::DSEL_MEM;
                if (i_stat.cur_zero) begin
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = bstk_pkg::RSEL_NEXT;
                    o_cmd.cur_dec = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/bstk_dp.sv */
// Datapath of the bounded stack: entry memory, occupancy, cursor and result registers.
module bstk_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [bstk_pkg::DATA_W-1:0] i_item_value,
    input  logic        [bstk_pkg::POS_W-1:0]  i_slot_position,
    input  bstk_pkg::t_dp_cmd                  i_cmd,
    output bstk_pkg::t_dp_stat                 o_stat,
    output logic                               o_valid,
    output logic        [bstk_pkg::STAT_W-1:0] o_status,
    output logic signed [bstk_pkg::DATA_W-1:0] o_read_data,
    output logic                               o_last
);

    logic signed [bstk_pkg::DATA_W-1:0] r_mem [bstk_pkg::DEPTH];
    logic signed [bstk_pkg::DATA_W-1:0] r_value;
    logic signed [bstk_pkg::DATA_W-1:0] r_rd_data;
    logic        [bstk_pkg::POS_W-1:0]  r_pos;
    logic        [bstk_pkg::OCC_W-1:0]  r_occ;
    logic        [bstk_pkg::AW-1:0]     r_cur;
    logic                               r_valid;
    logic        [bstk_pkg::STAT_W-1:0] r_status;
    logic signed [bstk_pkg::DATA_W-1:0] r_out_data;
    logic                               r_last;

    logic [bstk_pkg::OCC_W-1:0] occ_m1;
    logic [bstk_pkg::CMP_W-1:0] pos_ext;
    logic [bstk_pkg::CMP_W-1:0] occ_ext;
    logic [bstk_pkg::CMP_W-1:0] pos_m1;
    logic [bstk_pkg::AW-1:0]    wr_addr;
    logic [bstk_pkg::AW-1:0]    rd_addr;
    logic [bstk_pkg::AW-1:0]    cur_m1;

    // Address arithmetic and status flags.
    always_comb begin
        occ_m1  = r_occ - 1'b1;
        pos_ext = bstk_pkg::CMP_W'(r_pos);
        occ_ext = bstk_pkg::CMP_W'(r_occ);
        pos_m1  = pos_ext - 1'b1;
        cur_m1  = r_cur - 1'b1;
        wr_addr = (i_cmd.wr_sel == bstk_pkg::WSEL_POS) ? pos_m1[bstk_pkg::AW-1:0]
                                                       : r_occ[bstk_pkg::AW-1:0];
        rd_addr = (i_cmd.rd_sel == bstk_pkg::RSEL_NEXT) ? cur_m1
                                                        : occ_m1[bstk_pkg::AW-1:0];
        o_stat.empty    = (r_occ == '0);
        o_stat.full     = (r_occ == bstk_pkg::OCC_W'(bstk_pkg::DEPTH));
        o_stat.pos_ok   = (r_pos != '0) && (pos_ext <= occ_ext);
        o_stat.cur_zero = (r_cur == '0);
    end

    // Operand registers loaded with the input transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_item_value;
            r_pos   <= i_slot_position;
        end
    end

    // Entry memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[wr_addr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.occ_inc) begin
            r_occ <= r_occ + 1'b1;
        end else if (i_cmd.occ_dec) begin
            r_occ <= occ_m1;
        end
    end

    // Display cursor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load) begin
            r_cur <= occ_m1[bstk_pkg::AW-1:0];
        end else if (i_cmd.cur_dec) begin
            r_cur <= cur_m1;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_status <= i_cmd.out_status;
            r_last   <= i_cmd.out_last;
            case (i_cmd.out_dsel)
                bstk_pkg::DSEL_VALUE: r_out_data <= r_value;
                bstk_pkg::DSEL_MEM:   r_out_data <= r_rd_data;
                default:              r_out_data <= '0;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_read_data = r_out_data;
    assign o_last      = r_last;

endmodule

/* design/bounded_stack_with_update.sv */
// Top level of the bounded stack: controller and datapath.
//
//  Channel   Handshake                Fields
//  --------  -----------------------  ----------------------------------------
//  command   start (in), busy (out)   i_op, i_item_value, i_slot_position
//  result    o_valid strobe (out)     o_status, o_read_data, o_last
//
// A transaction is taken when start is high and busy is low. Push, update, unused
// codes and every refused operation keep busy high only in the decode state; pop
// and peek add a read-wait state for the registered read port of the entry memory.
// Display keeps busy high in the decode state and then in a display state per
// entry, and emits one result a cycle. Each result appears in the cycle after the
// busy cycle that forms it, so the final one overlaps the first cycle in which the
// next command can be taken. Reset clears the occupancy count, the controller
// state and the result strobe; the entry words are kept. The receiver cannot stall.
module bounded_stack_with_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [bstk_pkg::OP_W-1:0]    i_op,
    input  logic signed [bstk_pkg::DATA_W-1:0]  i_item_value,
    input  logic        [bstk_pkg::POS_W-1:0]   i_slot_position,
    output logic                                o_valid,
    output logic        [bstk_pkg::STAT_W-1:0]  o_status,
    output logic signed [bstk_pkg::DATA_W-1:0]  o_read_data,
    output logic                                o_last
);

    bstk_pkg::t_dp_cmd  cmd;
    bstk_pkg::t_dp_stat stat;

    // Sequencing of each operation.
    bstk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Storage and result formation.
    bstk_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_value    (i_item_value),
        .i_slot_position (i_slot_position),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_last          (o_last)
    );

endmodule
